### hw/rtl/rsls_pkg.sv
// ----------------------------------------------------------------------------
// rsls_pkg
// Shared constants for the radial spotlight luma scaler: register indexes,
// port widths and the fixed-point gain constants.
// ----------------------------------------------------------------------------
package rsls_pkg;

	// defaults for the top-level parameters
	localparam int COORD_BITS_DEF = 12;
	localparam int LUMA_BITS_DEF  = 16;

	// configuration port
	localparam int CFG_IDX_BITS  = 4;
	localparam int CFG_DATA_BITS = 14;

	localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X = 4'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y = 4'd1;

	// square root datapath: 32-bit radicand (d2 << 16), 16-bit root
	localparam int SQRT_BITS = 16;
	localparam int D2N_BITS  = 16;
	localparam int REM_BITS  = SQRT_BITS + 3;

	// gains in Q0.16, with one extra bit so that unity fits
	localparam int GAIN_BITS  = 17;
	localparam int SLOPE_BITS = 11;
	localparam int PROD_BITS  = SQRT_BITS + SLOPE_BITS;

	localparam logic [D2N_BITS-1:0]   FAR_D2    = 16'd25600;
	localparam logic [GAIN_BITS-1:0]  FAR_GAIN  = 17'd13107;
	localparam logic [GAIN_BITS-1:0]  GAIN_ONE  = 17'h10000;
	localparam logic [SLOPE_BITS-1:0] SLOPE_NUM = 11'd1311;

endpackage

### hw/rtl/radial_spotlight_luma_scale_top.sv
// ----------------------------------------------------------------------------
// radial_spotlight_luma_scale_top
// Dims each pixel's luminance by its distance from a configurable center:
// gain = 1 - 0.005 * distance, or a flat 0.2 at a distance of 160 or more.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle; 16 of the stages are the digit-by-digit
// square root, one result bit per stage. A stalled output only holds up the
// stages behind it that are full; empty stages still take new words.
// Reset: arst_n clears all stage valids and sets both center registers to 0.
module radial_spotlight_luma_scale_top #(
	parameter int COORD_BITS = rsls_pkg::COORD_BITS_DEF,
	parameter int LUMA_BITS  = rsls_pkg::LUMA_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// pixel input
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [COORD_BITS-1:0]              pixel_x,
	input  logic [COORD_BITS-1:0]              pixel_y,
	input  logic [LUMA_BITS-1:0]               luma_in,
	// pixel output
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [LUMA_BITS-1:0]               luma_out,
	// configuration writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rsls_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [rsls_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	localparam int CW   = rsls_pkg::CFG_DATA_BITS;
	// abs offset: up to 2^COORD_BITS - 1 + 2^(CW-1), or 2^(CW-1) - 1 the other way
	localparam int AW   = ((COORD_BITS > CW - 1) ? COORD_BITS : CW - 1) + 1;
	localparam int DW   = AW + 1;
	localparam int SQW  = 2 * AW;
	localparam int D2W  = SQW + 1;
	localparam int NSQ  = rsls_pkg::SQRT_BITS;
	localparam int RW   = rsls_pkg::REM_BITS;
	localparam int GW   = rsls_pkg::GAIN_BITS;
	localparam int PW   = rsls_pkg::PROD_BITS;
	localparam int NW   = rsls_pkg::D2N_BITS;

	localparam int S_ABS   = 1;
	localparam int S_SQ    = 2;
	localparam int S_D2    = 3;
	localparam int S_SQRT0 = 4;
	localparam int S_PROD  = S_SQRT0 + NSQ;
	localparam int S_GAIN  = S_PROD + 1;
	localparam int S_OUT   = S_GAIN + 1;
	localparam int NSTG    = S_OUT;

	// configuration registers
	logic signed [CW-1:0] center_x_q;
	logic signed [CW-1:0] center_y_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rsls_pkg::REG_CENTER_X: center_x_q <= cfg_data;
				rsls_pkg::REG_CENTER_Y: center_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage valids and load enables; a stage loads when empty or when it drains
	logic [NSTG:1] vld_q;
	logic [NSTG:1] en;

	always_comb begin
		en[NSTG] = !vld_q[NSTG] || !out_stall;
		for (int k = NSTG - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1])
				vld_q[1] <= in_valid;
			for (int k = 2; k <= NSTG; k++) begin
				if (en[k])
					vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign in_stall  = !en[1];
	assign out_valid = vld_q[NSTG];

	// luma rides along with every stage up to s21
	logic [LUMA_BITS-1:0] luma_s [1:NSTG-1];

	always_ff @(posedge clk) begin
		if (en[1])
			luma_s[1] <= luma_in;
		for (int k = 2; k <= NSTG - 1; k++) begin
			if (en[k])
				luma_s[k] <= luma_s[k-1];
		end
	end

	// s1: absolute offsets from the center
	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] dy;
	logic [AW-1:0]        ax_s1;
	logic [AW-1:0]        ay_s1;

	always_comb begin
		dx = DW'(signed'({1'b0, pixel_x})) - DW'(center_x_q);
		dy = DW'(signed'({1'b0, pixel_y})) - DW'(center_y_q);
	end

	always_ff @(posedge clk) begin
		if (en[S_ABS]) begin
			ax_s1 <= dx[DW-1] ? AW'(-dx) : AW'(dx);
			ay_s1 <= dy[DW-1] ? AW'(-dy) : AW'(dy);
		end
	end

	// s2: squares
	logic [SQW-1:0] sqx_s2;
	logic [SQW-1:0] sqy_s2;

	always_ff @(posedge clk) begin
		if (en[S_SQ]) begin
			sqx_s2 <= SQW'(ax_s1) * SQW'(ax_s1);
			sqy_s2 <= SQW'(ay_s1) * SQW'(ay_s1);
		end
	end

	// s3: squared distance, far test; sqrt stage inputs at index 0
	logic [D2W-1:0] d2;
	logic           sqrt_far_s  [0:NSQ];
	logic [NW-1:0]  sqrt_d2_s   [0:NSQ];
	logic [RW-1:0]  sqrt_rem_s  [0:NSQ];
	logic [NSQ-1:0] sqrt_root_s [0:NSQ];

	assign d2 = D2W'(sqx_s2) + D2W'(sqy_s2);

	always_ff @(posedge clk) begin
		if (en[S_D2]) begin
			sqrt_far_s[0]  <= d2 >= D2W'(rsls_pkg::FAR_D2);
			sqrt_d2_s[0]   <= d2[NW-1:0];
			sqrt_rem_s[0]  <= '0;
			sqrt_root_s[0] <= '0;
		end
	end

	// s4..s19: square root of d2 << 16, one root bit per stage
	for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
		localparam int I = NSQ - 1 - j;
		logic [1:0]    pair;
		logic [RW-1:0] rsh;
		logic [RW-1:0] trial;

		if (I >= NSQ / 2) begin : g_hi
			assign pair = sqrt_d2_s[j][2*(I - NSQ/2) +: 2];
		end else begin : g_lo
			// low half of the radicand is the << 16
			assign pair = 2'b00;
		end

		always_comb begin
			rsh   = {sqrt_rem_s[j][RW-3:0], pair};
			trial = {1'b0, sqrt_root_s[j], 2'b01};
		end

		always_ff @(posedge clk) begin
			if (en[S_SQRT0 + j]) begin
				sqrt_far_s[j+1] <= sqrt_far_s[j];
				sqrt_d2_s[j+1]  <= sqrt_d2_s[j];
				if (rsh >= trial) begin
					sqrt_rem_s[j+1]  <= rsh - trial;
					sqrt_root_s[j+1] <= {sqrt_root_s[j][NSQ-2:0], 1'b1};
				end else begin
					sqrt_rem_s[j+1]  <= rsh;
					sqrt_root_s[j+1] <= {sqrt_root_s[j][NSQ-2:0], 1'b0};
				end
			end
		end
	end

	// s20: slope product
	logic [PW-1:0] prod_s20;
	logic          far_s20;

	always_ff @(posedge clk) begin
		if (en[S_PROD]) begin
			prod_s20 <= PW'(sqrt_root_s[NSQ]) * PW'(rsls_pkg::SLOPE_NUM);
			far_s20  <= sqrt_far_s[NSQ];
		end
	end

	// s21: gain select
	logic [GW-1:0] gain_s21;

	always_ff @(posedge clk) begin
		if (en[S_GAIN]) begin
			gain_s21 <= far_s20 ? rsls_pkg::FAR_GAIN
			                    : rsls_pkg::GAIN_ONE - GW'(prod_s20[PW-1:10]);
		end
	end

	// s22: scale and truncate
	localparam int LPW = LUMA_BITS + GW;
	logic [LPW-1:0]       scaled;
	logic [LUMA_BITS-1:0] luma_s22;

	assign scaled = LPW'(luma_s[S_GAIN]) * LPW'(gain_s21);

	always_ff @(posedge clk) begin
		if (en[S_OUT])
			luma_s22 <= scaled[LUMA_BITS+15:16];
	end

	assign luma_out = luma_s22;

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the radial spotlight luma scaler. A short table of
// directed pixels (extremes, the 160-pixel boundary, centers off the image)
// runs first, then phases of random pixels, most of them near a random center.
// Expected luma words come from the table where it types them in, else from a
// bit-exact integer model of the falloff, and are matched in order against the
// output stream, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int COORD_W     = rsls_pkg::COORD_BITS_DEF;
	localparam int LUMA_W      = rsls_pkg::LUMA_BITS_DEF;
	localparam int CFG_IDX_W   = rsls_pkg::CFG_IDX_BITS;
	localparam int CFG_DATA_W  = rsls_pkg::CFG_DATA_BITS;
	localparam int COORD_MAX   = (1 << COORD_W) - 1;
	localparam int LUMA_MAX    = (1 << LUMA_W) - 1;
	localparam int CENTER_LO   = -4096;
	localparam int CENTER_HI   = 8191;
	localparam int NEAR_SPAN   = 170;
	localparam int SLOPE_SHIFT = 10;
	localparam int RANDOM_PIXELS = 700;
	localparam int LATENCY     = 22;
	localparam int DRAIN_LIMIT = 20000;
	localparam int HOLD_CYCLES = 150;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST = '1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_IDX_W'(rsls_pkg::REG_CENTER_Y + 1);

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic [COORD_W-1:0]      pixel_x;
	logic [COORD_W-1:0]      pixel_y;
	logic [LUMA_W-1:0]       luma_in;
	logic                    out_valid;
	logic                    out_stall;
	logic [LUMA_W-1:0]       luma_out;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	radial_spotlight_luma_scale_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.luma_in   (luma_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.luma_out  (luma_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// directed pixels; want is typed in only when known is set
	typedef struct packed {
		logic signed [CFG_DATA_W-1:0] cx;
		logic signed [CFG_DATA_W-1:0] cy;
		logic [COORD_W-1:0]           x;
		logic [COORD_W-1:0]           y;
		logic [LUMA_W-1:0]            luma;
		logic                         known;
		logic [LUMA_W-1:0]            want;
	} probe_row_t;

	localparam int N_PROBES = 20;
	probe_row_t probe_tbl [N_PROBES] = '{
		'{14'sd0,     14'sd0,     12'd0,    12'd0,    16'd65535, 1'b1, 16'd65535},
		'{14'sd0,     14'sd0,     12'd0,    12'd0,    16'd0,     1'b1, 16'd0},
		'{14'sd0,     14'sd0,     12'd4095, 12'd4095, 16'd65535, 1'b1, 16'd13106},
		'{14'sd0,     14'sd0,     12'd160,  12'd0,    16'd65535, 1'b1, 16'd13106},
		'{14'sd0,     14'sd0,     12'd0,    12'd160,  16'd40000, 1'b1, 16'd7999},
		'{14'sd0,     14'sd0,     12'd159,  12'd0,    16'd65535, 1'b0, 16'd0},
		'{14'sd0,     14'sd0,     12'd159,  12'd17,   16'd65535, 1'b0, 16'd0},
		'{14'sd0,     14'sd0,     12'd1,    12'd0,    16'd65535, 1'b0, 16'd0},
		'{14'sd0,     14'sd0,     12'd1,    12'd1,    16'd65535, 1'b0, 16'd0},
		'{14'sd0,     14'sd0,     12'd2730, 12'd1365, 16'd43690, 1'b1, 16'd8737},
		'{14'sd0,     14'sd0,     12'd1365, 12'd2730, 16'd21845, 1'b1, 16'd4368},
		'{-14'sd4096, -14'sd4096, 12'd0,    12'd0,    16'd65535, 1'b1, 16'd13106},
		'{-14'sd4096, -14'sd4096, 12'd4095, 12'd4095, 16'd65535, 1'b1, 16'd13106},
		'{14'sd8191,  14'sd8191,  12'd4095, 12'd4095, 16'd65535, 1'b1, 16'd13106},
		'{14'sd8191,  14'sd8191,  12'd0,    12'd0,    16'd1,     1'b1, 16'd0},
		'{14'sd4195,  14'sd0,     12'd4095, 12'd0,    16'd65535, 1'b0, 16'd0},
		'{-14'sd100,  -14'sd50,   12'd0,    12'd0,    16'd65535, 1'b0, 16'd0},
		'{14'sd2048,  14'sd2048,  12'd2048, 12'd2048, 16'd32768, 1'b1, 16'd32768},
		'{14'sd2048,  14'sd2048,  12'd2100, 12'd2000, 16'd65535, 1'b0, 16'd0},
		'{14'sd2048,  14'sd2048,  12'd2047, 12'd2048, 16'd1,     1'b0, 16'd0}
	};

	logic [LUMA_W-1:0] luma_expect_q [$];
	int                spot_cx;
	int                spot_cy;
	int                fail_count;
	int                hold_asks;
	bit                tx_calm;

	// ------------------------------------------------------------------
	// falloff model
	// ------------------------------------------------------------------
	function automatic logic [LUMA_W-1:0] dimmed_luma(logic [COORD_W-1:0] x,
			logic [COORD_W-1:0] y, logic [LUMA_W-1:0] luma);
		longint            dx;
		longint            dy;
		longint unsigned   d2;
		longint unsigned   radicand;
		longint unsigned   root;
		longint unsigned   trial;
		longint unsigned   gain;
		longint unsigned   prod;
		dx = longint'(x) - longint'(spot_cx);
		dy = longint'(y) - longint'(spot_cy);
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		d2 = longint'(dx * dx + dy * dy);
		if (d2 >= longint'(rsls_pkg::FAR_D2)) begin
			gain = longint'(rsls_pkg::FAR_GAIN);
		end else begin
			// exact floor(sqrt(d2 * 2^16)), one root bit at a time
			radicand = d2 << 16;
			root = 0;
			for (int b = rsls_pkg::SQRT_BITS - 1; b >= 0; b--) begin
				trial = root | (64'd1 << b);
				if (trial * trial <= radicand)
					root = trial;
			end
			gain = longint'(rsls_pkg::GAIN_ONE)
			     - ((root * longint'(rsls_pkg::SLOPE_NUM)) >> SLOPE_SHIFT);
		end
		prod = longint'(luma) * gain;
		return prod[LUMA_W+15:16];
	endfunction

	// ------------------------------------------------------------------
	// clock, reset, timeout
	// ------------------------------------------------------------------
	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// ------------------------------------------------------------------
	// sender side
	// ------------------------------------------------------------------
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (tx_calm || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic send_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
			logic [LUMA_W-1:0] luma, bit known, logic [LUMA_W-1:0] want);
		int gap;
		@(negedge clk);
		in_valid = 1'b1;
		pixel_x  = x;
		pixel_y  = y;
		luma_in  = luma;
		do @(posedge clk); while (in_stall);
		luma_expect_q.push_back(known ? want : dimmed_luma(x, y, luma));
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (luma_expect_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = CFG_DATA_W'(value);
		do @(posedge clk); while (!cfg_ready);
		if (idx == rsls_pkg::REG_CENTER_X)
			spot_cx = int'($signed(cfg_data));
		else if (idx == rsls_pkg::REG_CENTER_Y)
			spot_cy = int'($signed(cfg_data));
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [COORD_W-1:0] near_coord(int c);
		int v;
		v = c + int'($urandom_range(0, 2 * NEAR_SPAN)) - NEAR_SPAN;
		if (v < 0) v = 0;
		if (v > COORD_MAX) v = COORD_MAX;
		return COORD_W'(v);
	endfunction

	function automatic int pick_center();
		case ($urandom_range(0, 5))
			0: return ($urandom_range(0, 1) != 0) ? CENTER_LO : CENTER_HI;
			1: return -int'($urandom_range(1, 200));
			2: return COORD_MAX + int'($urandom_range(1, 200));
			3: return int'($urandom_range(0, CENTER_HI - CENTER_LO)) + CENTER_LO;
			default: return int'($urandom_range(0, COORD_MAX));
		endcase
	endfunction

	initial begin
		int                 sent;
		int                 phase_len;
		int                 guard;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [LUMA_W-1:0]  luma;

		in_valid   = 1'b0;
		pixel_x    = '0;
		pixel_y    = '0;
		luma_in    = '0;
		cfg_valid  = 1'b0;
		cfg_index  = rsls_pkg::REG_CENTER_X;
		cfg_data   = '0;
		spot_cx    = 0;
		spot_cy    = 0;
		fail_count = 0;
		hold_asks  = 0;
		tx_calm    = 1'b0;
		@(posedge arst_n);

		// directed table; the first rows run on the reset center
		for (int i = 0; i < N_PROBES; i++) begin
			if (int'(probe_tbl[i].cx) != spot_cx || int'(probe_tbl[i].cy) != spot_cy) begin
				wait_drained();
				write_reg(rsls_pkg::REG_CENTER_X, int'(probe_tbl[i].cx));
				write_reg(rsls_pkg::REG_CENTER_Y, int'(probe_tbl[i].cy));
			end
			send_pixel(probe_tbl[i].x, probe_tbl[i].y, probe_tbl[i].luma,
				probe_tbl[i].known, probe_tbl[i].want);
		end

		// writes to unused indexes must leave the center alone
		wait_drained();
		write_reg(CFG_IDX_LAST, 0);
		write_reg(CFG_IDX_SPARE, CENTER_LO);
		for (int i = 0; i < 4; i++)
			send_pixel(near_coord(spot_cx), near_coord(spot_cy), LUMA_W'(LUMA_MAX), 1'b0, '0);

		// random phases, each with its own center
		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			wait_drained();
			write_reg(rsls_pkg::REG_CENTER_X, pick_center());
			write_reg(rsls_pkg::REG_CENTER_Y, pick_center());
			if ($urandom_range(0, 2) == 0)
				write_reg(CFG_IDX_W'($urandom_range(int'(CFG_IDX_SPARE), int'(CFG_IDX_LAST))),
					int'($urandom_range(0, CENTER_HI - CENTER_LO)) + CENTER_LO);
			tx_calm   = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(20, 90);
			for (int i = 0; i < phase_len; i++) begin
				// long receiver hold while words keep coming
				if (sent == 100 || sent == 420) begin
					hold_asks++;
					tx_calm = 1'b1;
				end
				if ($urandom_range(0, 3) != 0) begin
					x = near_coord(spot_cx);
					y = near_coord(spot_cy);
				end else begin
					x = COORD_W'($urandom_range(0, COORD_MAX));
					y = COORD_W'($urandom_range(0, COORD_MAX));
				end
				case ($urandom_range(0, 9))
					0: luma = '0;
					1: luma = LUMA_W'(LUMA_MAX);
					default: luma = LUMA_W'($urandom_range(0, LUMA_MAX));
				endcase
				send_pixel(x, y, luma, 1'b0, '0);
				sent++;
			end
		end

		@(negedge clk);
		in_valid = 1'b0;
		guard = 0;
		while (luma_expect_q.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (LATENCY + 8) @(posedge clk);
		if (luma_expect_q.size() != 0) begin
			$error("%0d luma words never came out", luma_expect_q.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// ------------------------------------------------------------------
	// receiver side
	// ------------------------------------------------------------------
	initial begin
		int                stall_left;
		int                holds_seen;
		int                calm_left;
		bit                rx_calm;
		logic [LUMA_W-1:0] want;

		out_stall  = 1'b0;
		stall_left = 0;
		holds_seen = 0;
		calm_left  = 0;
		rx_calm    = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (luma_expect_q.size() == 0) begin
					$error("unexpected luma word %0d", luma_out);
					fail_count++;
				end else begin
					want = luma_expect_q.pop_front();
					if (luma_out !== want) begin
						$error("luma_out mismatch: expected %0d, actual %0d", want, luma_out);
						fail_count++;
					end
				end
			end
			@(negedge clk);
			if (calm_left == 0) begin
				rx_calm   = ($urandom_range(0, 2) == 0);
				calm_left = $urandom_range(50, 300);
			end
			calm_left--;
			if (holds_seen != hold_asks) begin
				holds_seen = hold_asks;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && !rx_calm && $urandom_range(0, 5) == 0) begin
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				                                         : $urandom_range(1, 3);
			end
			if (stall_left > 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

endmodule
